@@ sv/msc_pkg.sv @@
// Shared types, widths and constants for the magnetometer sample calibrator.
// No dependencies; used by msc_lane, msc_merge and the top level.
`timescale 1ns / 1ps

package msc_pkg;

  localparam int NUM_AXES       = 3;
  localparam int AXIS_Z         = 2;
  localparam int RAW_W          = 16;
  localparam int OUT_W          = 24;
  localparam int ASA_W          = 8;
  localparam int SENS_W         = ASA_W + 1;        // asa + 128, up to 383
  localparam int PROD_W         = 25;               // raw * (asa + 128)
  localparam int MAG_W          = 24;
  localparam int K_W            = 12;
  localparam int DIV_W          = 12;               // divisor is 2^12 - 1
  localparam int SCL_W          = MAG_W + K_W;      // mag * K + bias
  localparam int Q_W            = SCL_W - DIV_W;
  localparam int V_W            = 26;
  localparam int COEF_W         = 16;
  localparam int COEF_FRAC_BITS = 14;
  localparam int ROW_W          = NUM_AXES * COEF_W;
  localparam int MAC_W          = V_W + COEF_W;
  localparam int ACC_W          = MAC_W + 2;
  localparam int CFG_IDX_W      = 3;
  localparam int LANE_LAT       = 6;
  localparam int MERGE_LAT      = 3;

  // value * 4912 / (2 * 4095) and value * 4912 / (8 * 4095), rounded half away:
  // q = (mag * K + 2047) / 4095
  localparam logic [K_W-1:0]   SCALE_14   = 12'd2456;
  localparam logic [K_W-1:0]   SCALE_16   = 12'd614;
  localparam logic [K_W-1:0]   ROUND_BIAS = 12'd2047;
  localparam logic [DIV_W:0]   DIVISOR    = 13'd4095;

  localparam logic [23:0]      SENS_RESET = 24'h808080;
  localparam logic [ROW_W-1:0] COEF_ONE   = ROW_W'(1) << COEF_FRAC_BITS;

  // self-test pass ranges, scaled by 256
  localparam logic signed [PROD_W-1:0] ST14_XY_LO = -25'sd12800;
  localparam logic signed [PROD_W-1:0] ST14_XY_HI = 25'sd12800;
  localparam logic signed [PROD_W-1:0] ST14_Z_LO  = -25'sd204800;
  localparam logic signed [PROD_W-1:0] ST14_Z_HI  = -25'sd51200;
  localparam logic signed [PROD_W-1:0] ST16_XY_LO = -25'sd51200;
  localparam logic signed [PROD_W-1:0] ST16_XY_HI = 25'sd51200;
  localparam logic signed [PROD_W-1:0] ST16_Z_LO  = -25'sd819200;
  localparam logic signed [PROD_W-1:0] ST16_Z_HI  = -25'sd204800;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENS  = 3'd0,
    REG_MODE  = 3'd1,
    REG_OFF_X = 3'd2,
    REG_OFF_Y = 3'd3,
    REG_OFF_Z = 3'd4,
    REG_ROW0  = 3'd5,
    REG_ROW1  = 3'd6,
    REG_ROW2  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic                    kind;
    logic signed [RAW_W-1:0] raw_x;
    logic signed [RAW_W-1:0] raw_y;
    logic signed [RAW_W-1:0] raw_z;
    logic                    overflow;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value_x;
    logic signed [OUT_W-1:0] value_y;
    logic signed [OUT_W-1:0] value_z;
    logic                    self_test_result;
    logic                    was_self_test;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic kind;
  } ctl_t;

  typedef struct packed {
    logic [ASA_W-1:0]         asa;
    logic                     mode16;
    logic signed [OUT_W-1:0]  offset;
    logic signed [PROD_W-1:0] st_lo;
    logic signed [PROD_W-1:0] st_hi;
  } lane_cfg_t;

  typedef struct packed {
    logic signed [V_W-1:0]   v;
    logic signed [OUT_W-1:0] st_val;
    logic                    st_pass;
  } lane_res_t;

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] x);
    if (&x[ACC_W-1:OUT_W-1] || ~|x[ACC_W-1:OUT_W-1]) begin
      sat_out = x[OUT_W-1:0];
    end else if (x[ACC_W-1]) begin
      sat_out = {1'b1, {(OUT_W-1){1'b0}}};
    end else begin
      sat_out = {1'b0, {(OUT_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ sv/msc_lane.sv @@
// One axis lane: sensitivity multiply, microtesla scaling by constant division,
// offset subtract and self-test range check. Depends on msc_pkg.
`timescale 1ns / 1ps

module msc_lane (
  input  logic                                 clk,
  input  logic signed [msc_pkg::RAW_W-1:0]     raw,
  input  msc_pkg::lane_cfg_t                   cfg,
  output msc_pkg::lane_res_t                   res
);

  typedef struct packed {
    logic                             neg;
    logic signed [msc_pkg::OUT_W-1:0] st_val;
    logic                             st_pass;
  } aux_t;

  // stage 1: sensitivity product
  logic [msc_pkg::SENS_W-1:0]               sens;
  logic signed [msc_pkg::RAW_W+msc_pkg::SENS_W:0] prod_full;
  logic signed [msc_pkg::PROD_W-1:0]        prod_r;

  // stage 2: magnitude times scale
  logic signed [msc_pkg::PROD_W-1:0]        prod_abs;
  logic [msc_pkg::MAG_W-1:0]                mag;
  logic [msc_pkg::K_W-1:0]                  k;
  logic [msc_pkg::SCL_W-1:0]                scl_nxt;
  logic [msc_pkg::SCL_W-1:0]                scl_r;
  aux_t                                     aux_nxt;
  aux_t                                     aux_r [5];

  // stages 3..5: divide by 2^12 - 1 via folded residues
  logic [msc_pkg::Q_W-1:0]                  q0_r;
  logic [msc_pkg::Q_W:0]                    r0_nxt;
  logic [msc_pkg::Q_W:0]                    r0_r;
  logic [msc_pkg::DIV_W:0]                  a1;
  logic [msc_pkg::Q_W-1:0]                  q1_r;
  logic [msc_pkg::DIV_W:0]                  r1_nxt;
  logic [msc_pkg::DIV_W:0]                  r1_r;
  logic [msc_pkg::DIV_W:0]                  r2;
  logic                                     corr;
  logic [msc_pkg::Q_W-1:0]                  q_nxt;
  logic [msc_pkg::Q_W-1:0]                  q_r;

  // stage 6: signed value minus offset
  logic signed [msc_pkg::V_W-1:0]           qs;
  logic signed [msc_pkg::V_W-1:0]           qv;
  logic signed [msc_pkg::V_W-1:0]           v_nxt;
  logic signed [msc_pkg::V_W-1:0]           v_r;

  assign sens      = {1'b0, cfg.asa} + msc_pkg::SENS_W'(128);
  assign prod_full = raw * $signed({1'b0, sens});

  assign prod_abs = prod_r[msc_pkg::PROD_W-1] ? -prod_r : prod_r;
  assign mag      = prod_abs[msc_pkg::MAG_W-1:0];
  assign k        = cfg.mode16 ? msc_pkg::SCALE_16 : msc_pkg::SCALE_14;
  assign scl_nxt  = {{msc_pkg::K_W{1'b0}}, mag} * {{msc_pkg::MAG_W{1'b0}}, k}
                  + {{msc_pkg::MAG_W{1'b0}}, msc_pkg::ROUND_BIAS};

  assign aux_nxt.neg     = prod_r[msc_pkg::PROD_W-1];
  assign aux_nxt.st_val  = msc_pkg::sat_out({{(msc_pkg::ACC_W-msc_pkg::PROD_W)
                                              {prod_r[msc_pkg::PROD_W-1]}}, prod_r});
  assign aux_nxt.st_pass = (prod_r >= cfg.st_lo) && (prod_r <= cfg.st_hi);

  assign r0_nxt = {1'b0, scl_r[msc_pkg::SCL_W-1:msc_pkg::DIV_W]}
                + {{(msc_pkg::Q_W-msc_pkg::DIV_W+1){1'b0}}, scl_r[msc_pkg::DIV_W-1:0]};

  assign a1     = r0_r[msc_pkg::Q_W:msc_pkg::DIV_W];
  assign r1_nxt = a1 + {1'b0, r0_r[msc_pkg::DIV_W-1:0]};

  assign r2    = {1'b0, r1_r[msc_pkg::DIV_W-1:0]} + {{msc_pkg::DIV_W{1'b0}}, r1_r[msc_pkg::DIV_W]};
  assign corr  = (r2 >= msc_pkg::DIVISOR);
  assign q_nxt = q1_r + {{(msc_pkg::Q_W-1){1'b0}}, r1_r[msc_pkg::DIV_W]}
               + {{(msc_pkg::Q_W-1){1'b0}}, corr};

  assign qs    = $signed({{(msc_pkg::V_W-msc_pkg::Q_W){1'b0}}, q_r});
  assign qv    = aux_r[3].neg ? -qs : qs;
  assign v_nxt = qv - {{(msc_pkg::V_W-msc_pkg::OUT_W){cfg.offset[msc_pkg::OUT_W-1]}}, cfg.offset};

  always_ff @(posedge clk) begin
    prod_r   <= prod_full[msc_pkg::PROD_W-1:0];
    scl_r    <= scl_nxt;
    aux_r[0] <= aux_nxt;
    for (int i = 1; i < 5; i++) begin
      aux_r[i] <= aux_r[i-1];
    end
    q0_r <= scl_r[msc_pkg::SCL_W-1:msc_pkg::DIV_W];
    r0_r <= r0_nxt;
    q1_r <= q0_r + {{(msc_pkg::Q_W-msc_pkg::DIV_W-1){1'b0}}, a1};
    r1_r <= r1_nxt;
    q_r  <= q_nxt;
    v_r  <= v_nxt;
  end

  assign res.v       = v_r;
  assign res.st_val  = aux_r[4].st_val;
  assign res.st_pass = aux_r[4].st_pass;

endmodule

@@ sv/msc_merge.sv @@
// Merge stage: soft-iron matrix over the three lane values, rounding,
// saturation and result select. Depends on msc_pkg.
`timescale 1ns / 1ps

module msc_merge (
  input  logic                                                clk,
  input  logic                                                rst_n,
  input  msc_pkg::ctl_t                                       ctl_in,
  input  msc_pkg::lane_res_t [msc_pkg::NUM_AXES-1:0]          lane_res,
  input  logic [msc_pkg::NUM_AXES-1:0][msc_pkg::ROW_W-1:0]    rows,
  output logic                                                out_valid,
  output msc_pkg::out_item_t                                  out_item
);

  logic signed [msc_pkg::MAC_W-1:0] mac_nxt [msc_pkg::NUM_AXES][msc_pkg::NUM_AXES];
  logic signed [msc_pkg::MAC_W-1:0] mac_r   [msc_pkg::NUM_AXES][msc_pkg::NUM_AXES];
  logic signed [msc_pkg::ACC_W-1:0] acc_nxt [msc_pkg::NUM_AXES];
  logic signed [msc_pkg::ACC_W-1:0] acc_r   [msc_pkg::NUM_AXES];
  logic signed [msc_pkg::ACC_W-1:0] rnd     [msc_pkg::NUM_AXES];
  logic signed [msc_pkg::OUT_W-1:0] val     [msc_pkg::NUM_AXES];
  logic signed [msc_pkg::OUT_W-1:0] stv1_r  [msc_pkg::NUM_AXES];
  logic signed [msc_pkg::OUT_W-1:0] stv2_r  [msc_pkg::NUM_AXES];
  logic                             pass1_r;
  logic                             pass2_r;
  msc_pkg::ctl_t                    ctl1_r;
  msc_pkg::ctl_t                    ctl2_r;
  logic                             out_valid_r;
  msc_pkg::out_item_t               out_item_nxt;
  msc_pkg::out_item_t               out_item_r;

  // out_j = sum_i v_i * T[i][j]
  always_comb begin
    for (int j = 0; j < msc_pkg::NUM_AXES; j++) begin
      for (int i = 0; i < msc_pkg::NUM_AXES; i++) begin
        mac_nxt[j][i] = lane_res[i].v * $signed(rows[i][msc_pkg::COEF_W*j +: msc_pkg::COEF_W]);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < msc_pkg::NUM_AXES; j++) begin
      acc_nxt[j] = {{2{mac_r[j][0][msc_pkg::MAC_W-1]}}, mac_r[j][0]}
                 + {{2{mac_r[j][1][msc_pkg::MAC_W-1]}}, mac_r[j][1]}
                 + {{2{mac_r[j][2][msc_pkg::MAC_W-1]}}, mac_r[j][2]};
    end
  end

  // round half away from zero: negative values take bias - 1
  always_comb begin
    for (int j = 0; j < msc_pkg::NUM_AXES; j++) begin
      rnd[j] = (acc_r[j] + (acc_r[j][msc_pkg::ACC_W-1]
               ? (msc_pkg::ACC_W'(1) << (msc_pkg::COEF_FRAC_BITS - 1)) - msc_pkg::ACC_W'(1)
               : (msc_pkg::ACC_W'(1) << (msc_pkg::COEF_FRAC_BITS - 1))))
               >>> msc_pkg::COEF_FRAC_BITS;
      val[j] = ctl2_r.kind ? stv2_r[j] : msc_pkg::sat_out(rnd[j]);
    end
  end

  assign out_item_nxt.value_x          = val[0];
  assign out_item_nxt.value_y          = val[1];
  assign out_item_nxt.value_z          = val[msc_pkg::AXIS_Z];
  assign out_item_nxt.self_test_result = ctl2_r.kind & pass2_r;
  assign out_item_nxt.was_self_test    = ctl2_r.kind;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r      <= '0;
      ctl2_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctl1_r      <= ctl_in;
      ctl2_r      <= ctl1_r;
      out_valid_r <= ctl2_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    mac_r      <= mac_nxt;
    acc_r      <= acc_nxt;
    pass1_r    <= lane_res[0].st_pass & lane_res[1].st_pass & lane_res[msc_pkg::AXIS_Z].st_pass;
    pass2_r    <= pass1_r;
    for (int i = 0; i < msc_pkg::NUM_AXES; i++) begin
      stv1_r[i] <= lane_res[i].st_val;
      stv2_r[i] <= stv1_r[i];
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

@@ sv/magnetometer_sample_calibrator.sv @@
// Magnetometer sample calibrator, top level: configuration registers, three axis lanes, merge.
// Path from accepted item to out_valid: 6 lane stages, 3 merge stages.
// Throughput: one item per clock while busy is low; the pipeline never stalls and the receiver cannot stall.
// Overflowed items are taken and dropped with no result.
// Reset (synchronous, rst_n low): pipeline emptied, busy high, registers to identity setup.
// Depends on msc_pkg, msc_lane, msc_merge.
`timescale 1ns / 1ps

module magnetometer_sample_calibrator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  msc_pkg::in_item_t                  in_item,
  output logic                               out_valid,
  output msc_pkg::out_item_t                 out_item,
  input  logic                               cfg_we,
  input  logic [msc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [msc_pkg::ROW_W-1:0]          cfg_data
);

  logic [msc_pkg::NUM_AXES*msc_pkg::ASA_W-1:0]             sens_r;
  logic                                                    mode_r;
  logic signed [msc_pkg::OUT_W-1:0]                        off_r [msc_pkg::NUM_AXES];
  logic [msc_pkg::NUM_AXES-1:0][msc_pkg::ROW_W-1:0]        row_r;

  msc_pkg::ctl_t                                           ctl_nxt;
  msc_pkg::ctl_t                                           ctl_r [msc_pkg::LANE_LAT];
  logic signed [msc_pkg::RAW_W-1:0]                        raw   [msc_pkg::NUM_AXES];
  msc_pkg::lane_cfg_t                                      lane_cfg [msc_pkg::NUM_AXES];
  msc_pkg::lane_res_t [msc_pkg::NUM_AXES-1:0]              lane_res;

  assign busy = ~rst_n;

  assign ctl_nxt.valid = start & ~busy & ~in_item.overflow;
  assign ctl_nxt.kind  = in_item.kind;

  assign raw[0]               = in_item.raw_x;
  assign raw[1]               = in_item.raw_y;
  assign raw[msc_pkg::AXIS_Z] = in_item.raw_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r <= msc_pkg::SENS_RESET;
      mode_r <= 1'b1;
      for (int i = 0; i < msc_pkg::NUM_AXES; i++) begin
        off_r[i] <= '0;
        row_r[i] <= msc_pkg::COEF_ONE << (msc_pkg::COEF_W * i);
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        msc_pkg::REG_SENS:  sens_r   <= cfg_data[msc_pkg::NUM_AXES*msc_pkg::ASA_W-1:0];
        msc_pkg::REG_MODE:  mode_r   <= cfg_data[0];
        msc_pkg::REG_OFF_X: off_r[0] <= cfg_data[msc_pkg::OUT_W-1:0];
        msc_pkg::REG_OFF_Y: off_r[1] <= cfg_data[msc_pkg::OUT_W-1:0];
        msc_pkg::REG_OFF_Z: off_r[msc_pkg::AXIS_Z] <= cfg_data[msc_pkg::OUT_W-1:0];
        msc_pkg::REG_ROW0:  row_r[0] <= cfg_data;
        msc_pkg::REG_ROW1:  row_r[1] <= cfg_data;
        msc_pkg::REG_ROW2:  row_r[msc_pkg::AXIS_Z] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < msc_pkg::LANE_LAT; k++) begin
        ctl_r[k] <= '0;
      end
    end else begin
      ctl_r[0] <= ctl_nxt;
      for (int k = 1; k < msc_pkg::LANE_LAT; k++) begin
        ctl_r[k] <= ctl_r[k-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < msc_pkg::NUM_AXES; i++) begin
      lane_cfg[i].asa    = sens_r[msc_pkg::ASA_W*i +: msc_pkg::ASA_W];
      lane_cfg[i].mode16 = mode_r;
      lane_cfg[i].offset = off_r[i];
      if (i == msc_pkg::AXIS_Z) begin
        lane_cfg[i].st_lo = mode_r ? msc_pkg::ST16_Z_LO : msc_pkg::ST14_Z_LO;
        lane_cfg[i].st_hi = mode_r ? msc_pkg::ST16_Z_HI : msc_pkg::ST14_Z_HI;
      end else begin
        lane_cfg[i].st_lo = mode_r ? msc_pkg::ST16_XY_LO : msc_pkg::ST14_XY_LO;
        lane_cfg[i].st_hi = mode_r ? msc_pkg::ST16_XY_HI : msc_pkg::ST14_XY_HI;
      end
    end
  end

  for (genvar g = 0; g < msc_pkg::NUM_AXES; g++) begin : g_lane
    msc_lane u_lane (
      .clk (clk),
      .raw (raw[g]),
      .cfg (lane_cfg[g]),
      .res (lane_res[g])
    );
  end

  msc_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_in    (ctl_r[msc_pkg::LANE_LAT-1]),
    .lane_res  (lane_res),
    .rows      (row_r),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

`ifndef SYNTHESIS
  localparam int TOTAL_LAT = msc_pkg::LANE_LAT + msc_pkg::MERGE_LAT;

  // every result traces back to one accepted, non-overflowed item
  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && !in_item.overflow, TOTAL_LAT))
    else $error("result without a matching accepted item");

  a_kind_echo: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.was_self_test == $past(in_item.kind, TOTAL_LAT)))
    else $error("was_self_test does not match the source item");

  a_pass_only_self_test: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.self_test_result) |-> out_item.was_self_test)
    else $error("self-test pass flagged on a measurement");
`endif

endmodule

@@ tb/msc_calibration_checker.sv @@
// Checker for the magnetometer sample calibrator: follows config writes, predicts each
// accepted item and compares results in order. Depends on msc_pkg.
`timescale 1ns / 1ps

module msc_calibration_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  msc_pkg::in_item_t              in_item,
  input  logic                           out_valid,
  input  msc_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [msc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msc_pkg::ROW_W-1:0]      cfg_data,
  output int                             mismatches,
  output int                             outstanding
);

  localparam longint FULL_SCALE_UT = 4912;
  localparam longint COUNTS_14     = 8190;
  localparam longint COUNTS_16     = 32760;
  localparam longint VALUE_FRAC    = 8;
  localparam longint SENS_BIAS     = 128;
  localparam longint SENS_DIV      = 256;
  localparam longint OUT_HI        = 64'sd8388607;
  localparam longint OUT_LO        = -64'sd8388608;

  logic [23:0]               sens;
  logic                      mode16;
  longint                    offs[3];
  logic [msc_pkg::ROW_W-1:0] rows[3];

  msc_pkg::out_item_t calibrated_q[$];

  function automatic longint div_nearest(input longint n, input longint d);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = (mag + d / 2) / d;
    return (n < 0) ? -q : q;
  endfunction

  function automatic longint clamp24(input longint v);
    if (v > OUT_HI) return OUT_HI;
    if (v < OUT_LO) return OUT_LO;
    return v;
  endfunction

  function automatic msc_pkg::out_item_t calibrate(input msc_pkg::in_item_t it);
    longint raw[3];
    longint prod[3];
    longint v[3];
    longint res[3];
    longint acc;
    longint den;
    longint xy_lo, xy_hi, z_lo, z_hi;
    logic   ok;
    msc_pkg::out_item_t r;
    raw[0] = longint'($signed(it.raw_x));
    raw[1] = longint'($signed(it.raw_y));
    raw[2] = longint'($signed(it.raw_z));
    for (int i = 0; i < 3; i++) begin
      prod[i] = raw[i] * (longint'(sens[8*i +: 8]) + SENS_BIAS);
    end
    ok = 1'b0;
    if (it.kind) begin
      xy_lo = mode16 ? longint'(msc_pkg::ST16_XY_LO) : longint'(msc_pkg::ST14_XY_LO);
      xy_hi = mode16 ? longint'(msc_pkg::ST16_XY_HI) : longint'(msc_pkg::ST14_XY_HI);
      z_lo  = mode16 ? longint'(msc_pkg::ST16_Z_LO)  : longint'(msc_pkg::ST14_Z_LO);
      z_hi  = mode16 ? longint'(msc_pkg::ST16_Z_HI)  : longint'(msc_pkg::ST14_Z_HI);
      ok = prod[0] >= xy_lo && prod[0] <= xy_hi &&
           prod[1] >= xy_lo && prod[1] <= xy_hi &&
           prod[2] >= z_lo  && prod[2] <= z_hi;
      for (int i = 0; i < 3; i++) begin
        res[i] = clamp24(div_nearest(prod[i] * (longint'(1) << VALUE_FRAC), SENS_DIV));
      end
    end else begin
      den = SENS_DIV * (mode16 ? COUNTS_16 : COUNTS_14);
      for (int i = 0; i < 3; i++) begin
        v[i] = div_nearest(prod[i] * FULL_SCALE_UT * (longint'(1) << VALUE_FRAC), den) - offs[i];
      end
      for (int j = 0; j < 3; j++) begin
        acc = 0;
        for (int i = 0; i < 3; i++) begin
          acc += v[i] * longint'($signed(rows[i][16*j +: 16]));
        end
        res[j] = clamp24(div_nearest(acc, longint'(1) << msc_pkg::COEF_FRAC_BITS));
      end
    end
    r.value_x          = 24'(res[0]);
    r.value_y          = 24'(res[1]);
    r.value_z          = 24'(res[2]);
    r.self_test_result = ok;
    r.was_self_test    = it.kind;
    return r;
  endfunction

  always @(posedge clk) begin
    msc_pkg::out_item_t want;
    logic bad;
    if (!rst_n) begin
      sens    = msc_pkg::SENS_RESET;
      mode16  = 1'b1;
      offs[0] = 0;
      offs[1] = 0;
      offs[2] = 0;
      rows[0] = msc_pkg::COEF_ONE;
      rows[1] = msc_pkg::COEF_ONE << 16;
      rows[2] = msc_pkg::COEF_ONE << 32;
      calibrated_q.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (calibrated_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: x=%0d y=%0d z=%0d st=%0b kind=%0b",
                     out_item.value_x, out_item.value_y, out_item.value_z,
                     out_item.self_test_result, out_item.was_self_test);
          end
        end else begin
          want = calibrated_q.pop_front();
          bad = (out_item.value_x !== want.value_x) ||
                (out_item.value_y !== want.value_y) ||
                (out_item.value_z !== want.value_z) ||
                (out_item.self_test_result !== want.self_test_result) ||
                (out_item.was_self_test !== want.was_self_test);
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected x=%0d y=%0d z=%0d st=%0b kind=%0b",
                       want.value_x, want.value_y, want.value_z,
                       want.self_test_result, want.was_self_test);
              $display("          got      x=%0d y=%0d z=%0d st=%0b kind=%0b",
                       out_item.value_x, out_item.value_y, out_item.value_z,
                       out_item.self_test_result, out_item.was_self_test);
            end
          end
        end
      end
      if (start && !busy && !in_item.overflow) begin
        calibrated_q.push_back(calibrate(in_item));
      end
      if (cfg_we) begin
        case (cfg_index)
          msc_pkg::REG_SENS:  sens    = cfg_data[23:0];
          msc_pkg::REG_MODE:  mode16  = cfg_data[0];
          msc_pkg::REG_OFF_X: offs[0] = longint'($signed(cfg_data[23:0]));
          msc_pkg::REG_OFF_Y: offs[1] = longint'($signed(cfg_data[23:0]));
          msc_pkg::REG_OFF_Z: offs[2] = longint'($signed(cfg_data[23:0]));
          msc_pkg::REG_ROW0:  rows[0] = cfg_data;
          msc_pkg::REG_ROW1:  rows[1] = cfg_data;
          msc_pkg::REG_ROW2:  rows[2] = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = calibrated_q.size();
  end

endmodule

@@ tb/testbench.sv @@
// Top of the calibrator testbench: clock, reset, config phases and bursty sample stimulus.
// Depends on msc_pkg, magnetometer_sample_calibrator and msc_calibration_checker.
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 206;
  localparam logic KIND_MEAS      = 1'b0;
  localparam logic KIND_SELF_TEST = 1'b1;

  typedef enum int {SETUP_NEAR_ID, SETUP_MAX, SETUP_MIN, SETUP_WILD} setup_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  msc_pkg::in_item_t             in_item = '0;
  logic                          out_valid;
  msc_pkg::out_item_t            out_item;
  logic                          cfg_we = 1'b0;
  logic [msc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [msc_pkg::ROW_W-1:0]     cfg_data = '0;

  int mismatches;
  int outstanding;
  int cycle_count = 0;
  int burst_left = 0;

  logic [23:0] cur_sens = msc_pkg::SENS_RESET;
  logic        cur_mode = 1'b1;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  magnetometer_sample_calibrator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  msc_calibration_checker i_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_item    (out_item),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  function automatic msc_pkg::in_item_t mk(input logic kind, input int x, input int y,
                                           input int z, input logic ovf);
    msc_pkg::in_item_t it;
    it.kind     = kind;
    it.raw_x    = 16'(x);
    it.raw_y    = 16'(y);
    it.raw_z    = 16'(z);
    it.overflow = ovf;
    return it;
  endfunction

  function automatic int next_burst();
    return ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12);
  endfunction

  function automatic int next_gap();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 4);
  endfunction

  // raw reading close to a self-test bound, or mid-range, for the current gain and mode
  function automatic logic [15:0] near_bound(input int axis);
    longint s, lo, hi, target;
    int     pick;
    s = longint'(cur_sens[8*axis +: 8]) + 128;
    if (axis == msc_pkg::AXIS_Z) begin
      lo = cur_mode ? longint'(msc_pkg::ST16_Z_LO) : longint'(msc_pkg::ST14_Z_LO);
      hi = cur_mode ? longint'(msc_pkg::ST16_Z_HI) : longint'(msc_pkg::ST14_Z_HI);
    end else begin
      lo = cur_mode ? longint'(msc_pkg::ST16_XY_LO) : longint'(msc_pkg::ST14_XY_LO);
      hi = cur_mode ? longint'(msc_pkg::ST16_XY_HI) : longint'(msc_pkg::ST14_XY_HI);
    end
    pick = $urandom_range(0, 3);
    target = (pick == 0) ? lo : (pick == 1) ? hi : (lo + hi) / 2;
    target = target / s + longint'($urandom_range(0, 4)) - 2;
    return 16'(target);
  endfunction

  function automatic msc_pkg::in_item_t make_sample();
    msc_pkg::in_item_t it;
    logic [15:0] r[3];
    int style;
    style = $urandom_range(0, 9);
    it.kind     = 1'($urandom_range(0, 1));
    it.overflow = ($urandom_range(0, 7) == 0);
    for (int i = 0; i < 3; i++) begin
      if (style < 4)      r[i] = 16'($urandom);
      else if (style < 7) r[i] = 16'(int'($urandom_range(0, 4000)) - 2000);
      else                r[i] = near_bound(i);
    end
    it.raw_x = r[0];
    it.raw_y = r[1];
    it.raw_z = r[2];
    return it;
  endfunction

  task automatic feed(input msc_pkg::in_item_t it, input bit last);
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    @(negedge clk);
    if (last || burst_left == 0) begin
      start <= 1'b0;
      if (!last) begin
        repeat (next_gap()) @(negedge clk);
        burst_left = next_burst();
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input msc_pkg::cfg_reg_t idx, input logic [47:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
  endtask

  function automatic logic [47:0] make_row(input int row, input setup_t sel);
    logic [47:0] d;
    int c;
    for (int j = 0; j < 3; j++) begin
      case (sel)
        SETUP_MAX: d[16*j +: 16] = 16'h7FFF;
        SETUP_MIN: d[16*j +: 16] = 16'h8000;
        SETUP_WILD: d[16*j +: 16] = 16'($urandom);
        default: begin
          c = int'($urandom_range(0, 6000)) - 3000;
          if (row == j) c += 1 << msc_pkg::COEF_FRAC_BITS;
          d[16*j +: 16] = 16'(c);
        end
      endcase
    end
    return d;
  endfunction

  task automatic load_setup(input setup_t sel);
    logic [23:0] off[3];
    for (int i = 0; i < 3; i++) begin
      case (sel)
        SETUP_MAX:     off[i] = 24'h7FFFFF;
        SETUP_MIN:     off[i] = 24'h800000;
        SETUP_WILD:    off[i] = 24'($urandom);
        default:       off[i] = 24'(int'($urandom_range(0, 131072)) - 65536);
      endcase
    end
    case (sel)
      SETUP_MAX: begin
        cur_sens = 24'hFFFFFF;
        cur_mode = 1'b0;
      end
      SETUP_MIN: begin
        cur_sens = 24'h000000;
        cur_mode = 1'b1;
      end
      default: begin
        cur_sens = 24'($urandom);
        cur_mode = 1'($urandom_range(0, 1));
      end
    endcase
    write_reg(msc_pkg::REG_SENS, 48'(cur_sens));
    write_reg(msc_pkg::REG_MODE, 48'(cur_mode));
    write_reg(msc_pkg::REG_OFF_X, 48'(off[0]));
    write_reg(msc_pkg::REG_OFF_Y, 48'(off[1]));
    write_reg(msc_pkg::REG_OFF_Z, 48'(off[2]));
    write_reg(msc_pkg::REG_ROW0, make_row(0, sel));
    write_reg(msc_pkg::REG_ROW1, make_row(1, sel));
    write_reg(msc_pkg::REG_ROW2, make_row(2, sel));
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(input int n);
    int made;
    msc_pkg::in_item_t it;
    made = 0;
    while (made < n) begin
      it = make_sample();
      made++;
      feed(it, made >= n);
    end
  endtask

  initial begin
    msc_pkg::in_item_t mode16_set[$];
    msc_pkg::in_item_t mode14_set[$];
    setup_t plan[8];
    plan = '{SETUP_MAX, SETUP_NEAR_ID, SETUP_MIN, SETUP_NEAR_ID,
             SETUP_WILD, SETUP_NEAR_ID, SETUP_WILD, SETUP_NEAR_ID};

    // reset setup: unit gain, 16-bit mode, identity matrix
    mode16_set.push_back(mk(KIND_MEAS, 0, 0, 0, 1'b0));
    mode16_set.push_back(mk(KIND_MEAS, 32767, 32767, 32767, 1'b0));
    mode16_set.push_back(mk(KIND_MEAS, -32768, -32768, -32768, 1'b0));
    mode16_set.push_back(mk(KIND_MEAS, 1, -1, 100, 1'b1));
    mode16_set.push_back(mk(KIND_SELF_TEST, 0, 0, -1000, 1'b1));
    mode16_set.push_back(mk(KIND_SELF_TEST, 200, -200, -800, 1'b0));
    mode16_set.push_back(mk(KIND_SELF_TEST, 201, 0, -1000, 1'b0));
    mode16_set.push_back(mk(KIND_SELF_TEST, 0, -201, -1000, 1'b0));
    mode16_set.push_back(mk(KIND_SELF_TEST, -200, 200, -3200, 1'b0));
    mode16_set.push_back(mk(KIND_SELF_TEST, 0, 0, -3201, 1'b0));
    mode16_set.push_back(mk(KIND_SELF_TEST, 0, 0, -799, 1'b0));
    mode16_set.push_back(mk(KIND_SELF_TEST, 32767, -32768, -32768, 1'b0));
    mode16_set.push_back(mk(KIND_MEAS, 12345, -23456, 7, 1'b0));
    // 14-bit mode: self-test bounds and two measurements
    mode14_set.push_back(mk(KIND_SELF_TEST, 50, -50, -200, 1'b0));
    mode14_set.push_back(mk(KIND_SELF_TEST, -51, 0, -500, 1'b0));
    mode14_set.push_back(mk(KIND_SELF_TEST, 0, 51, -500, 1'b0));
    mode14_set.push_back(mk(KIND_SELF_TEST, -50, 50, -800, 1'b0));
    mode14_set.push_back(mk(KIND_SELF_TEST, 0, 0, -801, 1'b0));
    mode14_set.push_back(mk(KIND_SELF_TEST, 0, 0, -199, 1'b0));
    mode14_set.push_back(mk(KIND_MEAS, 32767, -32768, 1, 1'b0));
    mode14_set.push_back(mk(KIND_MEAS, -1, 1, -1, 1'b0));

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    burst_left = next_burst();

    for (int k = 0; k < mode16_set.size(); k++) begin
      feed(mode16_set[k], k == mode16_set.size() - 1);
    end
    drain();

    cur_mode = 1'b0;
    write_reg(msc_pkg::REG_MODE, 48'(cur_mode));
    cfg_we <= 1'b0;
    @(negedge clk);
    for (int k = 0; k < mode14_set.size(); k++) begin
      feed(mode14_set[k], k == mode14_set.size() - 1);
    end
    drain();

    for (int p = 0; p < 8; p++) begin
      load_setup(plan[p]);
      run_phase(PHASE_ITEMS);
      drain();
    end

    if (mismatches == 0 && outstanding == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
